FILE: hw/rtl/pecu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pecu_pkg
// Shared types and codes for the easing curve pipeline: per-stage multiply
// operations, operand selects and constant codes.
// ----------------------------------------------------------------------------
package pecu_pkg;

  localparam int NMUL = 5;

  // operand A select
  localparam logic [1:0] A_R = 2'd0;
  localparam logic [1:0] A_X = 2'd1;
  localparam logic [1:0] A_H = 2'd2;
  localparam logic [1:0] A_K = 2'd3;

  // operand B select
  localparam logic B_X = 1'b0;
  localparam logic B_R = 1'b1;

  // multiplier constant codes
  localparam logic [2:0] K_HALF  = 3'd0;
  localparam logic [2:0] K_NHALF = 3'd1;
  localparam logic [2:0] K_C7    = 3'd2;
  localparam logic [2:0] K_S1    = 3'd3;
  localparam logic [2:0] K_S2P1  = 3'd4;

  // post-add constant codes
  localparam logic [3:0] C_ZERO = 4'd0;
  localparam logic [3:0] C_ONE  = 4'd1;
  localparam logic [3:0] C_NONE = 4'd2;
  localparam logic [3:0] C_TWO  = 4'd3;
  localparam logic [3:0] C_NTWO = 4'd4;
  localparam logic [3:0] C_S    = 4'd5;
  localparam logic [3:0] C_NS   = 4'd6;
  localparam logic [3:0] C_S2   = 4'd7;
  localparam logic [3:0] C_NS2  = 4'd8;
  localparam logic [3:0] C_B1   = 4'd9;
  localparam logic [3:0] C_B2   = 4'd10;
  localparam logic [3:0] C_B3   = 4'd11;
  localparam logic [3:0] C_IB1  = 4'd12;
  localparam logic [3:0] C_IB2  = 4'd13;
  localparam logic [3:0] C_IB3  = 4'd14;
  localparam logic [3:0] C_HALF = 4'd15;

  typedef struct packed {
    logic       en;
    logic [1:0] a_sel;
    logic       b_sel;
    logic       to_h;
    logic       neg;
    logic [2:0] kc;
    logic [3:0] ac;
  } op_t;

  typedef op_t [NMUL-1:0] prog_t;

  function automatic op_t mk_op(input logic [1:0] a, input logic b, input logic th,
                                input logic ng, input logic [2:0] kc,
                                input logic [3:0] ac);
    op_t o;
    o.en    = 1'b1;
    o.a_sel = a;
    o.b_sel = b;
    o.to_h  = th;
    o.neg   = ng;
    o.kc    = kc;
    o.ac    = ac;
    return o;
  endfunction

endpackage

FILE: hw/rtl/pecu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pecu_decode
// Clamps progress, forms the curve base value and registers the list of
// multiply operations that the following stages carry out.
// ----------------------------------------------------------------------------
module pecu_decode
  import pecu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [4:0]                mode,
  input  logic [16:0]               progress,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [FRAC_BITS+5:0] r,
  output logic signed [FRAC_BITS+5:0] x,
  output prog_t                     prog
);

  localparam int W  = FRAC_BITS + 6;
  localparam int PW = (W > 17) ? W : 17;
  localparam longint ONE_L  = longint'(1) <<< FRAC_BITS;
  localparam longint O6_L   = ((longint'(6) <<< FRAC_BITS) + 5) / 11;
  localparam longint O9_L   = ((longint'(9) <<< FRAC_BITS) + 5) / 11;
  localparam longint O21_L  = ((longint'(21) <<< FRAC_BITS) + 11) / 22;

  localparam logic signed [W-1:0] ONE   = W'(ONE_L);
  localparam logic signed [W-1:0] TWO   = W'(2 * ONE_L);
  localparam logic signed [W-1:0] THREE = W'(3 * ONE_L);
  localparam logic signed [W+3:0] LIM4  = (W+4)'(4 * ONE_L);
  localparam logic signed [W+3:0] LIM8  = (W+4)'(8 * ONE_L);
  localparam logic signed [W+3:0] LIM10 = (W+4)'(10 * ONE_L);

  localparam logic [2:0] FAM_QUAD   = 3'd0;
  localparam logic [2:0] FAM_CUBIC  = 3'd1;
  localparam logic [2:0] FAM_QUART  = 3'd2;
  localparam logic [2:0] FAM_QUINT  = 3'd3;
  localparam logic [2:0] FAM_BACK   = 3'd4;
  localparam logic [2:0] FAM_BOUNCE = 3'd5;
  localparam logic [2:0] FAM_LINEAR = 3'd6;

  localparam logic [1:0] FM_IN    = 2'd0;
  localparam logic [1:0] FM_OUT   = 2'd1;
  localparam logic [1:0] FM_INOUT = 2'd2;

  logic [PW-1:0]       pz;
  logic signed [W-1:0] k, k2, tb, r_next, x_next;
  logic signed [W+3:0] t11;
  logic [2:0]          fam, n, lo, hi;
  logic [1:0]          form;
  logic                inv, half2, sel2;
  op_t                 rx;
  prog_t               prog_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    pz = PW'(progress);
    k  = (pz > PW'(ONE_L)) ? ONE : W'(pz);
    k2 = k <<< 1;

    case (mode) inside
      [5'd1:5'd3]:   fam = FAM_QUAD;
      [5'd4:5'd6]:   fam = FAM_CUBIC;
      [5'd7:5'd9]:   fam = FAM_QUART;
      [5'd10:5'd12]: fam = FAM_QUINT;
      [5'd13:5'd15]: fam = FAM_BACK;
      [5'd16:5'd18]: fam = FAM_BOUNCE;
      default:       fam = FAM_LINEAR;
    endcase
    case (mode) inside
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16: form = FM_IN;
      5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17: form = FM_OUT;
      default:                               form = FM_INOUT;
    endcase

    n         = fam + 3'd2;
    rx        = mk_op(A_R, B_X, 1'b0, 1'b0, K_HALF, C_ZERO);
    prog_next = '0;
    r_next    = k;
    x_next    = k;
    lo        = 3'd0;
    hi        = 3'd0;
    inv       = 1'b0;
    half2     = 1'b0;
    sel2      = 1'b0;
    tb        = k;
    t11       = '0;

    case (fam)
      FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT: begin
        case (form)
          FM_IN: begin
            lo = 3'd0;
            hi = n - 3'd2;
          end
          FM_OUT: begin
            if (fam == FAM_QUAD) begin
              r_next = TWO - k;
            end else begin
              x_next = k - ONE;
              r_next = k - ONE;
              hi     = n - 3'd2;
            end
          end
          default: begin
            if (k2 < ONE) begin
              x_next = k2;
              r_next = k2;
              lo     = 3'd1;
              hi     = n - 3'd1;
            end else if (fam == FAM_QUAD) begin
              r_next = k2 - ONE;
              x_next = k2 - THREE;
            end else begin
              x_next = k2 - TWO;
              r_next = k2 - TWO;
              hi     = n - 3'd2;
            end
          end
        endcase
        for (int i = 0; i < NMUL; i++) begin
          if (3'(i) >= lo && 3'(i) <= hi) prog_next[i] = rx;
        end
        case (form)
          FM_OUT: begin
            if (fam != FAM_QUAD) begin
              prog_next[hi].ac  = C_ONE;
              prog_next[hi].neg = (fam == FAM_QUART);
            end
          end
          FM_INOUT: begin
            if (k2 < ONE) begin
              prog_next[0] = mk_op(A_K, B_X, 1'b0, 1'b0, K_HALF, C_ZERO);
            end else if (fam == FAM_QUAD) begin
              prog_next[0].ac = C_NONE;
              prog_next[1]    = mk_op(A_K, B_R, 1'b0, 1'b0, K_NHALF, C_ZERO);
            end else begin
              prog_next[hi].ac = n[0] ? C_TWO : C_NTWO;
              prog_next[hi + 3'd1] = mk_op(A_K, B_R, 1'b0, 1'b0,
                                           n[0] ? K_HALF : K_NHALF, C_ZERO);
            end
          end
          default: ;
        endcase
      end
      FAM_BACK: begin
        sel2 = (form == FM_INOUT);
        case (form)
          FM_IN:   half2 = 1'b0;
          FM_OUT:  half2 = 1'b1;
          default: half2 = !(k2 < ONE);
        endcase
        if (form == FM_INOUT) x_next = half2 ? (k2 - TWO) : k2;
        else                  x_next = half2 ? (k - ONE) : k;
        r_next = x_next;
        prog_next[0] = mk_op(A_X, B_X, 1'b1, 1'b0, K_HALF, C_ZERO);
        prog_next[1] = mk_op(A_K, B_X, 1'b0, 1'b0, sel2 ? K_S2P1 : K_S1,
                             half2 ? (sel2 ? C_S2 : C_S) : (sel2 ? C_NS2 : C_NS));
        prog_next[2] = mk_op(A_H, B_R, 1'b0, 1'b0, K_HALF,
                             half2 ? (sel2 ? C_TWO : C_ONE) : C_ZERO);
        if (sel2) prog_next[3] = mk_op(A_K, B_R, 1'b0, 1'b0, K_HALF, C_ZERO);
      end
      FAM_BOUNCE: begin
        case (form)
          FM_IN: begin
            tb  = ONE - k;
            inv = 1'b1;
          end
          FM_OUT: tb = k;
          default: begin
            half2 = !(k2 < ONE);
            tb    = half2 ? (k2 - ONE) : (ONE - k2);
            inv   = !half2;
          end
        endcase
        t11 = (W+4)'(tb) * (W+4)'(11);
        prog_next[0] = mk_op(A_K, B_X, 1'b0, 1'b0, K_C7, C_ZERO);
        if (t11 < LIM4) begin
          x_next = tb;
          prog_next[1] = mk_op(A_R, B_X, 1'b0, inv, K_HALF, inv ? C_ONE : C_ZERO);
        end else if (t11 < LIM8) begin
          x_next = tb - W'(O6_L);
          prog_next[1] = mk_op(A_R, B_X, 1'b0, inv, K_HALF, inv ? C_IB1 : C_B1);
        end else if (t11 < LIM10) begin
          x_next = tb - W'(O9_L);
          prog_next[1] = mk_op(A_R, B_X, 1'b0, inv, K_HALF, inv ? C_IB2 : C_B2);
        end else begin
          x_next = tb - W'(O21_L);
          prog_next[1] = mk_op(A_R, B_X, 1'b0, inv, K_HALF, inv ? C_IB3 : C_B3);
        end
        if (form == FM_INOUT)
          prog_next[2] = mk_op(A_K, B_R, 1'b0, 1'b0, K_HALF, half2 ? C_HALF : C_ZERO);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      r    <= r_next;
      x    <= x_next;
      prog <= prog_next;
    end
  end

endmodule

FILE: hw/rtl/pecu_mul_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pecu_mul_stage
// One pipeline stage: a floored fixed-point multiply with negate and
// post-add, as selected by this stage's operation word.
// ----------------------------------------------------------------------------
module pecu_mul_stage
  import pecu_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int IDX       = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [FRAC_BITS+5:0] r_in,
  input  logic signed [FRAC_BITS+5:0] x_in,
  input  logic signed [FRAC_BITS+5:0] h_in,
  input  prog_t                       prog_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+5:0] r,
  output logic signed [FRAC_BITS+5:0] x,
  output logic signed [FRAC_BITS+5:0] h,
  output prog_t                       prog
);

  localparam int W = FRAC_BITS + 6;
  localparam longint ONE_L  = longint'(1) <<< FRAC_BITS;
  localparam longint HALF_L = ONE_L / 2;
  localparam longint C7_L   = ((longint'(121) <<< FRAC_BITS) + 8) / 16;
  localparam longint S_L    = ((longint'(170158) <<< FRAC_BITS) + 50000) / 100000;
  localparam longint S2_L   =
    ((longint'(259490950) <<< FRAC_BITS) + 50000000) / 100000000;
  localparam longint B1_L   = ((longint'(3) <<< FRAC_BITS) + 2) / 4;
  localparam longint B2_L   = ((longint'(15) <<< FRAC_BITS) + 8) / 16;
  localparam longint B3_L   = ((longint'(63) <<< FRAC_BITS) + 32) / 64;

  op_t                   op;
  logic signed [W-1:0]   a, b, kval, aval, q, res, r_next, h_next;
  logic signed [2*W-1:0] prod;

  assign op       = prog_in[IDX];
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    case (op.kc)
      K_HALF:  kval = W'(HALF_L);
      K_NHALF: kval = W'(-HALF_L);
      K_C7:    kval = W'(C7_L);
      K_S1:    kval = W'(S_L + ONE_L);
      K_S2P1:  kval = W'(S2_L + ONE_L);
      default: kval = '0;
    endcase
    case (op.ac)
      C_ONE:   aval = W'(ONE_L);
      C_NONE:  aval = W'(-ONE_L);
      C_TWO:   aval = W'(2 * ONE_L);
      C_NTWO:  aval = W'(-2 * ONE_L);
      C_S:     aval = W'(S_L);
      C_NS:    aval = W'(-S_L);
      C_S2:    aval = W'(S2_L);
      C_NS2:   aval = W'(-S2_L);
      C_B1:    aval = W'(B1_L);
      C_B2:    aval = W'(B2_L);
      C_B3:    aval = W'(B3_L);
      C_IB1:   aval = W'(ONE_L - B1_L);
      C_IB2:   aval = W'(ONE_L - B2_L);
      C_IB3:   aval = W'(ONE_L - B3_L);
      C_HALF:  aval = W'(HALF_L);
      default: aval = '0;
    endcase
    case (op.a_sel)
      A_R:     a = r_in;
      A_X:     a = x_in;
      A_H:     a = h_in;
      default: a = kval;
    endcase
    b      = (op.b_sel == B_R) ? r_in : x_in;
    prod   = (2*W)'(a) * (2*W)'(b);
    q      = W'(prod >>> FRAC_BITS);
    res    = (op.neg ? -q : q) + aval;
    r_next = r_in;
    h_next = h_in;
    if (op.en) begin
      if (op.to_h) h_next = res;
      else         r_next = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      r    <= r_next;
      x    <= x_in;
      h    <= h_next;
      prog <= prog_in;
    end
  end

endmodule

FILE: hw/rtl/pecu_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pecu_sat
// Output stage: clamp to -0.5 .. 1.5 and hold the word for the consumer.
// ----------------------------------------------------------------------------
module pecu_sat
  import pecu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [FRAC_BITS+5:0] r_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [17:0]          eased
);

  localparam int W  = FRAC_BITS + 6;
  localparam int OW = (W > 18) ? W : 18;
  localparam longint HALF_L = (longint'(1) <<< FRAC_BITS) / 2;
  localparam logic signed [W-1:0] LO = W'(-HALF_L);
  localparam logic signed [W-1:0] HI = W'(3 * HALF_L);

  logic signed [W-1:0]  sat;
  logic signed [OW-1:0] ext;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    if (r_in < LO)      sat = LO;
    else if (r_in > HI) sat = HI;
    else                sat = r_in;
    ext = OW'(sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      eased <= ext[17:0];
    end
  end

endmodule

FILE: hw/rtl/polynomial_easing_curve_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_easing_curve_unit
// Polynomial, back and bounce easing curves over a fixed-point progress
// value, evaluated in a seven-stage pipeline.
//
//   channel  | handshake              | fields
//   request  | req_valid / req_ready  | mode[4:0], progress[16:0]
//   response | rsp_valid / rsp_ready  | eased[17:0] signed
//
// One word per cycle sustained while rsp_ready is high; a word passes decode,
// five multiply stages (longest chain of dependent multiplies) and saturate.
// Reset clears the valid bits only; no state is held between words.
// Each stage holds its word while the next one is full, so a stall at the
// response drains bubbles first and loses or repeats nothing.
// ----------------------------------------------------------------------------
module polynomial_easing_curve_unit
  import pecu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [4:0]         mode,
  input  logic [16:0]        progress,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic signed [17:0] eased
);

  localparam int W = FRAC_BITS + 6;

  logic                v   [NMUL+1];
  logic                rdy [NMUL+1];
  logic signed [W-1:0] r   [NMUL+1];
  logic signed [W-1:0] x   [NMUL+1];
  logic signed [W-1:0] h   [NMUL+1];
  prog_t               prog[NMUL+1];
  logic                sat_ready;

  assign h[0] = '0;

  pecu_decode #(.FRAC_BITS(FRAC_BITS)) u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .mode      (mode),
    .progress  (progress),
    .out_valid (v[0]),
    .out_ready (rdy[0]),
    .r         (r[0]),
    .x         (x[0]),
    .prog      (prog[0])
  );

  for (genvar i = 0; i < NMUL; i++) begin : g_mul
    pecu_mul_stage #(.FRAC_BITS(FRAC_BITS), .IDX(i)) u_mul (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_ready  (rdy[i]),
      .r_in      (r[i]),
      .x_in      (x[i]),
      .h_in      (h[i]),
      .prog_in   (prog[i]),
      .out_valid (v[i+1]),
      .out_ready (rdy[i+1]),
      .r         (r[i+1]),
      .x         (x[i+1]),
      .h         (h[i+1]),
      .prog      (prog[i+1])
    );
  end

  assign rdy[NMUL] = sat_ready;

  pecu_sat #(.FRAC_BITS(FRAC_BITS)) u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[NMUL]),
    .in_ready  (sat_ready),
    .r_in      (r[NMUL]),
    .out_valid (rsp_valid),
    .out_ready (rsp_ready),
    .eased     (eased)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid straight after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v[0] && v[1] && v[2] && v[3] && v[4] && v[5] && rsp_valid && !rsp_ready)
      |-> !req_ready)
    else $error("request taken while pipeline full and stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && FRAC_BITS <= 16) |-> (eased >= -18'sd32768 && eased <= 18'sd98304))
    else $error("eased value outside saturation range");

endmodule
